/* src/nearest_points_to_seed_select_top_assert.svh */
// ----------------------------------------------------------------------------
// nearest_points_to_seed_select_top assertion macros
// Shared property wrappers, clocked on aclk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINTS_TO_SEED_SELECT_TOP_ASSERT_SVH
`define NEAREST_POINTS_TO_SEED_SELECT_TOP_ASSERT_SVH

// same-cycle implication
`define NPSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("npss: same-cycle check failed");

// next-cycle implication
`define NPSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("npss: next-cycle check failed");

`endif

/* src/npss_pkg.sv */
// ----------------------------------------------------------------------------
// npss_pkg
// Sizes, codes and types of the nearest-point selector.
// ----------------------------------------------------------------------------
`default_nettype none

package npss_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 16;

    localparam int IDX_W     = $clog2(MAX_POINTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int DIFF_W    = COORD_BITS + 1;
    localparam int MAG_W     = COORD_BITS;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int DIST_W    = SQ_W + 2;
    localparam int RATIO_W   = 17;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = RATIO_W + CNT_W;
    localparam int ENTRY_W   = 3 * COORD_BITS + 1;
    localparam int MARK_BIT  = 3 * COORD_BITS;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [RATIO_W-1:0] RATIO_ONE  = RATIO_W'(1 << FRAC_W);
    localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(1 << (FRAC_W - 1));
    localparam logic [CNT_W-1:0]   CNT_FULL   = CNT_W'(MAX_POINTS);

    localparam logic [IDX_W-1:0]  SEED_RESET = '0;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_FETCH = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // register select bit of paddr
    localparam logic REG_SEED_INDEX = 1'b0;
    localparam logic REG_KEEP_RATIO = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SEED  = 8'b0000_0010,
        S_SEEDW = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_DRAIN = 8'b0001_0000,
        S_FIN   = 8'b0010_0000,
        S_FINW  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

/* src/nearest_points_to_seed_select_top.sv */
// ----------------------------------------------------------------------------
// nearest_points_to_seed_select_top
// Point cloud store that returns points in rising squared distance from a seed.
// ----------------------------------------------------------------------------
// Points are loaded one per transaction into a 1024-entry store; each fetch
// returns the nearest point to the stored seed (seed_index) that has not been
// returned yet, ties to the lower index, until round(keep_ratio * count) points
// have gone out. A fetch that finds nothing left skips the scan. The store has
// one read port: the scan reads every loaded entry once through a four-stage
// distance pipeline, then rereads the winner and writes its emitted mark back.
// Results sit in an output register, so a load or clear can be accepted while
// an earlier result still waits. No clearing pass is needed after reset.
`default_nettype none

module nearest_points_to_seed_select_top (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // input channel
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [1:0]                             s_opcode,
    input  wire logic signed [npss_pkg::COORD_BITS-1:0] s_coord_x,
    input  wire logic signed [npss_pkg::COORD_BITS-1:0] s_coord_y,
    input  wire logic signed [npss_pkg::COORD_BITS-1:0] s_coord_z,
    // result channel
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [npss_pkg::IDX_W-1:0]                  m_point_index,
    output logic signed [npss_pkg::COORD_BITS-1:0]      m_out_x,
    output logic signed [npss_pkg::COORD_BITS-1:0]      m_out_y,
    output logic signed [npss_pkg::COORD_BITS-1:0]      m_out_z,
    output logic [npss_pkg::DIST_W-1:0]                 m_dist_sq,
    output logic                                        m_last_point,
    output logic [1:0]                                  m_status,
    // configuration port
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [npss_pkg::APB_AW-1:0]            paddr,
    input  wire logic [npss_pkg::APB_DW-1:0]            pwdata,
    output logic [npss_pkg::APB_DW-1:0]                 prdata,
    output logic                                        pready
);

`include "nearest_points_to_seed_select_top_assert.svh"

    localparam int CB = npss_pkg::COORD_BITS;

    // configuration
    logic [npss_pkg::IDX_W-1:0]   seed_index_reg;
    logic [npss_pkg::RATIO_W-1:0] keep_ratio_reg;
    logic                         apb_wr;

    // control
    npss_pkg::state_t             state_reg, state_next;
    logic [npss_pkg::CNT_W-1:0]   loaded_cnt_reg;
    logic [npss_pkg::CNT_W-1:0]   emitted_cnt_reg;
    logic [npss_pkg::CNT_W-1:0]   kept_reg;
    logic [npss_pkg::CNT_W-1:0]   scan_cnt_reg;
    logic                         s_fire;
    npss_pkg::op_t                op;
    logic                         store_full;
    logic                         nothing_left;
    logic                         scan_last;
    logic                         pipe_busy;
    logic                         emit_go;

    // ratio scaling
    logic [npss_pkg::RATIO_W-1:0] ratio_sat;
    logic [npss_pkg::PROD_W-1:0]  kept_prod;

    // point store: {mark, x, y, z}
    logic [npss_pkg::ENTRY_W-1:0] point_mem [npss_pkg::MAX_POINTS];
    logic                         mem_we;
    logic [npss_pkg::IDX_W-1:0]   mem_waddr;
    logic [npss_pkg::ENTRY_W-1:0] mem_wdata;
    logic [npss_pkg::IDX_W-1:0]   mem_raddr;
    logic [npss_pkg::ENTRY_W-1:0] rd_data_reg;

    // seed
    logic signed [CB-1:0]         seed_x_reg, seed_y_reg, seed_z_reg;

    // distance pipeline
    logic                         rd_vld_reg;
    logic [npss_pkg::IDX_W-1:0]   rd_idx_reg;
    logic                         df_vld_reg, df_mark_reg;
    logic [npss_pkg::IDX_W-1:0]   df_idx_reg;
    logic [npss_pkg::MAG_W-1:0]   df_x_reg, df_y_reg, df_z_reg;
    logic                         sq_vld_reg, sq_mark_reg;
    logic [npss_pkg::IDX_W-1:0]   sq_idx_reg;
    logic [npss_pkg::SQ_W-1:0]    sq_x_reg, sq_y_reg, sq_z_reg;
    logic                         sm_vld_reg, sm_mark_reg;
    logic [npss_pkg::IDX_W-1:0]   sm_idx_reg;
    logic [npss_pkg::DIST_W-1:0]  sm_dist_reg;
    logic signed [npss_pkg::DIFF_W-1:0] dx, dy, dz;
    logic [npss_pkg::MAG_W-1:0]   mx, my, mz;

    // best candidate
    logic                         found_reg;
    logic [npss_pkg::IDX_W-1:0]   best_idx_reg;
    logic [npss_pkg::DIST_W-1:0]  best_d_reg;

    // pending result and output register
    logic [npss_pkg::IDX_W-1:0]   res_idx_reg;
    logic [CB-1:0]                res_x_reg, res_y_reg, res_z_reg;
    logic [npss_pkg::DIST_W-1:0]  res_dist_reg;
    logic                         res_last_reg;
    npss_pkg::status_t            res_status_reg;
    logic                         m_valid_reg;
    logic [npss_pkg::IDX_W-1:0]   m_idx_reg;
    logic [CB-1:0]                m_x_reg, m_y_reg, m_z_reg;
    logic [npss_pkg::DIST_W-1:0]  m_dist_reg;
    logic                         m_last_reg;
    npss_pkg::status_t            m_status_reg;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_index_reg <= npss_pkg::SEED_RESET;
            keep_ratio_reg <= npss_pkg::RATIO_ONE;
        end else if (apb_wr) begin
            unique case (paddr[2])
                npss_pkg::REG_SEED_INDEX: seed_index_reg <= pwdata[npss_pkg::IDX_W-1:0];
                npss_pkg::REG_KEEP_RATIO: keep_ratio_reg <= pwdata[npss_pkg::RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            npss_pkg::REG_SEED_INDEX:
                prdata = npss_pkg::APB_DW'(seed_index_reg);
            npss_pkg::REG_KEEP_RATIO:
                prdata = npss_pkg::APB_DW'(keep_ratio_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------------
    assign s_ready    = (state_reg == npss_pkg::S_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign op         = npss_pkg::op_t'(s_opcode);
    assign store_full = (loaded_cnt_reg == npss_pkg::CNT_FULL);
    assign scan_last  = ((scan_cnt_reg + 1'b1) == loaded_cnt_reg);
    assign pipe_busy  = rd_vld_reg || df_vld_reg || sq_vld_reg || sm_vld_reg;
    assign emit_go    = !m_valid_reg || m_ready;

    assign ratio_sat = (keep_ratio_reg > npss_pkg::RATIO_ONE) ? npss_pkg::RATIO_ONE
                                                              : keep_ratio_reg;
    assign kept_prod = npss_pkg::PROD_W'(ratio_sat) * npss_pkg::PROD_W'(loaded_cnt_reg);

    assign nothing_left = (loaded_cnt_reg == '0)
                       || (npss_pkg::CNT_W'(seed_index_reg) >= loaded_cnt_reg)
                       || (emitted_cnt_reg >= kept_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            npss_pkg::S_IDLE: begin
                if (s_fire) begin
                    case (op)
                        npss_pkg::OP_LOAD:  if (store_full) state_next = npss_pkg::S_EMIT;
                        npss_pkg::OP_FETCH: state_next = npss_pkg::S_SEED;
                        default: ;
                    endcase
                end
            end
            npss_pkg::S_SEED:  state_next = npss_pkg::S_SEEDW;
            npss_pkg::S_SEEDW: state_next = nothing_left ? npss_pkg::S_EMIT : npss_pkg::S_SCAN;
            npss_pkg::S_SCAN:  if (scan_last) state_next = npss_pkg::S_DRAIN;
            npss_pkg::S_DRAIN: if (!pipe_busy) state_next = npss_pkg::S_FIN;
            npss_pkg::S_FIN:   state_next = found_reg ? npss_pkg::S_FINW : npss_pkg::S_EMIT;
            npss_pkg::S_FINW:  state_next = npss_pkg::S_EMIT;
            npss_pkg::S_EMIT:  if (emit_go) state_next = npss_pkg::S_IDLE;
            default:           state_next = npss_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= npss_pkg::S_IDLE;
            loaded_cnt_reg  <= '0;
            emitted_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                case (op)
                    npss_pkg::OP_LOAD:  if (!store_full) loaded_cnt_reg <= loaded_cnt_reg + 1'b1;
                    npss_pkg::OP_CLEAR: begin
                        loaded_cnt_reg  <= '0;
                        emitted_cnt_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (state_reg == npss_pkg::S_FINW) begin
                emitted_cnt_reg <= emitted_cnt_reg + 1'b1;
            end
        end
    end

    // kept count and scan address
    always_ff @(posedge aclk) begin
        if (state_reg == npss_pkg::S_SEED) begin
            kept_reg <= kept_prod[npss_pkg::FRAC_W +: npss_pkg::CNT_W]
                      + kept_prod[npss_pkg::FRAC_W-1 -: 1];
        end
        if (state_reg == npss_pkg::S_SEEDW) begin
            scan_cnt_reg <= '0;
        end else if (state_reg == npss_pkg::S_SCAN) begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // point store: one write port, one registered read port
    // ------------------------------------------------------------------------
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = loaded_cnt_reg[npss_pkg::IDX_W-1:0];
        mem_wdata = {1'b0, s_coord_x, s_coord_y, s_coord_z};
        if (s_fire && (op == npss_pkg::OP_LOAD) && !store_full) begin
            mem_we = 1'b1;
        end else if (state_reg == npss_pkg::S_FINW) begin
            // mark the winner as emitted, coordinates written back unchanged
            mem_we    = 1'b1;
            mem_waddr = best_idx_reg;
            mem_wdata = {1'b1, rd_data_reg[npss_pkg::MARK_BIT-1:0]};
        end
    end

    always_comb begin
        unique case (state_reg)
            npss_pkg::S_SCAN: mem_raddr = scan_cnt_reg[npss_pkg::IDX_W-1:0];
            npss_pkg::S_FIN:  mem_raddr = best_idx_reg;
            default:          mem_raddr = seed_index_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            point_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= point_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == npss_pkg::S_SEEDW) begin
            seed_x_reg <= rd_data_reg[2*CB +: CB];
            seed_y_reg <= rd_data_reg[CB +: CB];
            seed_z_reg <= rd_data_reg[0 +: CB];
        end
    end

    // ------------------------------------------------------------------------
    // distance pipeline: read, difference, square, sum, compare
    // ------------------------------------------------------------------------
    assign dx = npss_pkg::DIFF_W'(signed'(rd_data_reg[2*CB +: CB]))
              - npss_pkg::DIFF_W'(seed_x_reg);
    assign dy = npss_pkg::DIFF_W'(signed'(rd_data_reg[CB +: CB]))
              - npss_pkg::DIFF_W'(seed_y_reg);
    assign dz = npss_pkg::DIFF_W'(signed'(rd_data_reg[0 +: CB]))
              - npss_pkg::DIFF_W'(seed_z_reg);

    // a coordinate difference magnitude always fits in COORD_BITS
    assign mx = dx[npss_pkg::DIFF_W-1] ? npss_pkg::MAG_W'(-dx) : npss_pkg::MAG_W'(dx);
    assign my = dy[npss_pkg::DIFF_W-1] ? npss_pkg::MAG_W'(-dy) : npss_pkg::MAG_W'(dy);
    assign mz = dz[npss_pkg::DIFF_W-1] ? npss_pkg::MAG_W'(-dz) : npss_pkg::MAG_W'(dz);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            df_vld_reg <= 1'b0;
            sq_vld_reg <= 1'b0;
            sm_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= (state_reg == npss_pkg::S_SCAN);
            df_vld_reg <= rd_vld_reg;
            sq_vld_reg <= df_vld_reg;
            sm_vld_reg <= sq_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg  <= scan_cnt_reg[npss_pkg::IDX_W-1:0];

        df_idx_reg  <= rd_idx_reg;
        df_mark_reg <= rd_data_reg[npss_pkg::MARK_BIT];
        df_x_reg    <= mx;
        df_y_reg    <= my;
        df_z_reg    <= mz;

        sq_idx_reg  <= df_idx_reg;
        sq_mark_reg <= df_mark_reg;
        sq_x_reg    <= npss_pkg::SQ_W'(df_x_reg) * npss_pkg::SQ_W'(df_x_reg);
        sq_y_reg    <= npss_pkg::SQ_W'(df_y_reg) * npss_pkg::SQ_W'(df_y_reg);
        sq_z_reg    <= npss_pkg::SQ_W'(df_z_reg) * npss_pkg::SQ_W'(df_z_reg);

        sm_idx_reg  <= sq_idx_reg;
        sm_mark_reg <= sq_mark_reg;
        sm_dist_reg <= npss_pkg::DIST_W'(sq_x_reg) + npss_pkg::DIST_W'(sq_y_reg)
                     + npss_pkg::DIST_W'(sq_z_reg);
    end

    // strict less-than keeps the lower index on equal distances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (state_reg == npss_pkg::S_SEEDW) begin
            found_reg <= 1'b0;
        end else if (sm_vld_reg && !sm_mark_reg && (!found_reg || sm_dist_reg < best_d_reg)) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (sm_vld_reg && !sm_mark_reg && (!found_reg || sm_dist_reg < best_d_reg)) begin
            best_idx_reg <= sm_idx_reg;
            best_d_reg   <= sm_dist_reg;
        end
    end

    // ------------------------------------------------------------------------
    // result assembly and output register
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_fire && (op == npss_pkg::OP_LOAD) && store_full) begin
            res_idx_reg    <= '0;
            res_x_reg      <= '0;
            res_y_reg      <= '0;
            res_z_reg      <= '0;
            res_dist_reg   <= '0;
            res_last_reg   <= 1'b0;
            res_status_reg <= npss_pkg::ST_FULL;
        end else if (((state_reg == npss_pkg::S_SEEDW) && nothing_left)
                  || ((state_reg == npss_pkg::S_FIN) && !found_reg)) begin
            res_idx_reg    <= '0;
            res_x_reg      <= '0;
            res_y_reg      <= '0;
            res_z_reg      <= '0;
            res_dist_reg   <= '0;
            res_last_reg   <= 1'b0;
            res_status_reg <= npss_pkg::ST_EMPTY;
        end else if (state_reg == npss_pkg::S_FINW) begin
            res_idx_reg    <= best_idx_reg;
            res_x_reg      <= rd_data_reg[2*CB +: CB];
            res_y_reg      <= rd_data_reg[CB +: CB];
            res_z_reg      <= rd_data_reg[0 +: CB];
            res_dist_reg   <= best_d_reg;
            res_last_reg   <= ((emitted_cnt_reg + 1'b1) == kept_reg);
            res_status_reg <= npss_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == npss_pkg::S_EMIT) && emit_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == npss_pkg::S_EMIT) && emit_go) begin
            m_idx_reg    <= res_idx_reg;
            m_x_reg      <= res_x_reg;
            m_y_reg      <= res_y_reg;
            m_z_reg      <= res_z_reg;
            m_dist_reg   <= res_dist_reg;
            m_last_reg   <= res_last_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_point_index = m_idx_reg;
    assign m_out_x       = m_x_reg;
    assign m_out_y       = m_y_reg;
    assign m_out_z       = m_z_reg;
    assign m_dist_sq     = m_dist_reg;
    assign m_last_point  = m_last_reg;
    assign m_status      = m_status_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `NPSS_ASSERT_NOW(a_emit_le_loaded, 1'b1, emitted_cnt_reg <= loaded_cnt_reg)
    `NPSS_ASSERT_NOW(a_fin_after_drain, state_reg == npss_pkg::S_FIN, !pipe_busy)
    `NPSS_ASSERT_NEXT(a_emit_count_step, state_reg == npss_pkg::S_FINW,
        emitted_cnt_reg == $past(emitted_cnt_reg) + 1'b1)

endmodule

`default_nettype wire
